// ===== sv/ssr_pkg.sv =====
`timescale 1ns / 1ps

package ssr_pkg;

  localparam int unsigned JOB_BYTES   = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [COUNT_W-1:0] MAX_PATTERN     = 4'd8;
  localparam logic [COUNT_W-1:0] MAX_REPLACEMENT = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LIMIT       = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
    logic       truncated;
  } out_t;

  // One classified input byte: the bytes it releases, the end marker and the
  // truncation flag that every resulting transfer carries.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [COUNT_W-1:0]        count;
    logic                      eot;
    logic                      trunc;
  } job_t;

endpackage

// ===== sv/ssr_front.sv =====
`timescale 1ns / 1ps

module ssr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  ssr_pkg::in_t                    item,
  input  logic                            queue_full,
  output logic                            push,
  output ssr_pkg::job_t                   job
);
  import ssr_pkg::*;

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;
  logic [15:0] output_limit;

  logic [JOB_BYTES-1:0][7:0] window;
  logic [2:0]                fill;
  logic [15:0]               emitted;
  logic                      dropped;

  logic [COUNT_W-1:0]        plen;
  logic [2:0]                plen_m1;
  logic [COUNT_W-1:0]        rlen;
  logic [2:0]                f0;
  logic [JOB_BYTES-1:0][7:0] wn;
  logic                      full;
  logic                      hit;
  logic [COUNT_W-1:0]        raw;
  logic [JOB_BYTES-1:0][7:0] sel_bytes;
  logic                      has_room;
  logic [15:0]               room;
  logic                      over;
  logic [COUNT_W-1:0]        kept;
  logic                      take;

  always_comb begin
    plen = pattern_length;
    if (plen == 4'd0) plen = 4'd1;
    if (plen > MAX_PATTERN) plen = MAX_PATTERN;
    plen_m1 = 3'(plen - 4'd1);
    rlen = (replacement_length > MAX_REPLACEMENT) ? MAX_REPLACEMENT : replacement_length;
  end

  // Insert the new byte and compare the whole window in parallel.
  always_comb begin
    f0 = ({1'b0, fill} >= plen) ? 3'd0 : fill;
    for (int i = 0; i < JOB_BYTES; i++) begin
      wn[i] = (3'(i) == f0) ? item.in_byte : window[i];
    end
    full = ({1'b0, f0} + 4'd1) == plen;
    hit  = full;
    for (int i = 0; i < JOB_BYTES; i++) begin
      if (4'(i) < plen && wn[i] != pattern_bytes[8*i +: 8]) hit = 1'b0;
    end
  end

  always_comb begin
    sel_bytes = wn;
    if (hit) begin
      sel_bytes = replacement_bytes;
      raw       = rlen;
    end else if (full) begin
      raw = item.is_last ? plen : 4'd1;
    end else begin
      raw = item.is_last ? ({1'b0, f0} + 4'd1) : 4'd0;
    end
  end

  // Once the text has kept output_limit - 1 bytes every further byte is dropped, so the
  // kept part of this step is a prefix of its bytes.
  always_comb begin
    has_room = ({1'b0, emitted} + 17'd1) < {1'b0, output_limit};
    room     = output_limit - emitted - 16'd1;
    if (!has_room) begin
      over = raw != 4'd0;
      kept = 4'd0;
    end else begin
      over = room < {12'd0, raw};
      kept = over ? room[COUNT_W-1:0] : raw;
    end
  end

  assign item_stall = queue_full;
  assign take       = item_valid && !queue_full;
  assign push       = take && (kept != 4'd0 || item.is_last);

  always_comb begin
    job.bytes = sel_bytes;
    job.count = kept;
    job.eot   = item.is_last;
    job.trunc = dropped | over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= 4'd0;
      output_limit       <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        CFG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        CFG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        CFG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        CFG_OUTPUT_LIMIT:       output_limit       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= 3'd0;
      window  <= '0;
      emitted <= 16'd0;
      dropped <= 1'b0;
    end else if (cfg_we && cfg_index == CFG_PATTERN_LENGTH) begin
      fill   <= 3'd0;
      window <= '0;
    end else if (take) begin
      if (item.is_last) begin
        fill    <= 3'd0;
        emitted <= 16'd0;
        dropped <= 1'b0;
      end else begin
        emitted <= emitted + {12'd0, kept};
        dropped <= dropped | over;
        if (hit) begin
          window <= wn;
          fill   <= 3'd0;
        end else if (full) begin
          for (int i = 0; i < JOB_BYTES - 1; i++) window[i] <= wn[i+1];
          window[JOB_BYTES-1] <= 8'd0;
          fill <= plen_m1;
        end else begin
          window <= wn;
          fill   <= f0 + 3'd1;
        end
      end
    end
  end

endmodule

// ===== sv/ssr_queue.sv =====
`timescale 1ns / 1ps

module ssr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssr_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output ssr_pkg::job_t head
);
  import ssr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// ===== sv/ssr_back.sv =====
`timescale 1ns / 1ps

module ssr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  ssr_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output ssr_pkg::out_t out_data
);
  import ssr_pkg::*;

  logic [2:0] idx;
  logic       last_res;
  logic       load;
  out_t       res;

  // A job without bytes is a bare end marker and yields a single transfer.
  assign last_res = (head.count == 4'd0) || ({1'b0, idx} == (head.count - 4'd1));
  assign load     = head_valid && (!out_valid || !out_stall);
  assign pop      = load && last_res;

  always_comb begin
    res.byte_valid  = head.count != 4'd0;
    res.out_byte    = res.byte_valid ? head.bytes[idx] : 8'd0;
    res.end_of_text = head.eot && last_res;
    res.truncated   = head.trunc;
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last_res ? 3'd0 : idx + 3'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/streaming_substring_replace.sv =====
`timescale 1ns / 1ps
// An input transfer's first result is registered in the job queue, then in out_data.
// Throughput: one input byte per cycle while each byte releases at most one result
// and out_stall is low. A match or end-of-text flush releasing n bytes holds out_data
// for n results, one per unstalled cycle; the queue absorbs up to QUEUE_DEPTH steps.
// Reset is synchronous: it restores the register defaults, empties window and queue.
module streaming_substring_replace #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ssr_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ssr_pkg::out_t                   out_data
);
  import ssr_pkg::*;

  logic push;
  job_t push_job;
  logic pop;
  logic q_full;
  logic head_valid;
  job_t head;

  ssr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (in_valid),
    .item_stall (in_stall),
    .item       (in_data),
    .queue_full (q_full),
    .push       (push),
    .job        (push_job)
  );

  ssr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ssr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job queue written while full");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job queue read while empty");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.end_of_text && out_data.out_byte == 8'd0)
    else $error("result without a byte is not a clean end marker");

  // Within one text the truncation flag may rise but never fall.
  a_trunc_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.end_of_text && out_data.truncated
    |=> !out_valid || out_data.truncated)
    else $error("truncation flag fell within a text");

endmodule

// ===== sim/tb_streaming_substring_replace.sv =====
`timescale 1ns / 1ps

module tb_streaming_substring_replace;
  import ssr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 10;
  localparam int HOLD_OFF       = 300;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;

  streaming_substring_replace u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copy of the registers and of the scanning state.
  logic [63:0] pat_word;
  logic [3:0]  pat_len_reg;
  logic [63:0] rep_word;
  logic [3:0]  rep_len_reg;
  logic [15:0] limit_reg;
  logic [7:0]  window_q [8];
  int unsigned window_fill;
  int unsigned emitted_count;
  bit          dropped;
  logic [7:0]  step_bytes [$];
  out_t        expected_text [$];

  int fail_count   = 0;
  bit idling_on    = 1'b1;
  int hold_request = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_window();
    int i;
    for (i = 0; i < 8; i++) window_q[i] = 8'h00;
    window_fill = 0;
  endfunction

  function automatic void reset_shadow();
    pat_word      = '0;
    pat_len_reg   = 4'd1;
    rep_word      = '0;
    rep_len_reg   = 4'd0;
    limit_reg     = 16'hFFFF;
    emitted_count = 0;
    dropped       = 1'b0;
    clear_window();
  endfunction

  function automatic int unsigned active_pattern_len();
    if (pat_len_reg < 1) return 1;
    if (pat_len_reg > MAX_PATTERN) return MAX_PATTERN;
    return pat_len_reg;
  endfunction

  function automatic int unsigned active_replacement_len();
    if (rep_len_reg > MAX_REPLACEMENT) return MAX_REPLACEMENT;
    return rep_len_reg;
  endfunction

  // Bytes beyond the output budget of the text are dropped and flagged.
  function automatic void emit_byte(logic [7:0] b);
    if (emitted_count + 1 < limit_reg && step_bytes.size() < 16) begin
      step_bytes    = {step_bytes, b};
      emitted_count = (emitted_count + 1) & 16'hFFFF;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function automatic void scan_and_replace(in_t item);
    int unsigned plen;
    int unsigned rlen;
    int          i;
    bit          hit;
    out_t        res;
    plen = active_pattern_len();
    step_bytes.delete();
    if (window_fill >= plen) window_fill = 0;
    window_q[window_fill % 8] = item.in_byte;
    window_fill++;
    if (window_fill == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++)
        if (window_q[i] != pat_word[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        rlen = active_replacement_len();
        for (i = 0; i < rlen; i++) emit_byte(rep_word[8*i +: 8]);
        window_fill = 0;
      end else begin
        emit_byte(window_q[0]);
        for (i = 0; i < 7; i++) window_q[i] = window_q[i+1];
        window_q[7] = 8'h00;
        window_fill--;
      end
    end
    if (item.is_last) begin
      for (i = 0; i < window_fill && i < 8; i++) emit_byte(window_q[i]);
      window_fill = 0;
    end
    foreach (step_bytes[k]) begin
      res.out_byte    = step_bytes[k];
      res.byte_valid  = 1'b1;
      res.end_of_text = 1'b0;
      res.truncated   = dropped;
      expected_text   = {expected_text, res};
    end
    if (item.is_last) begin
      if (step_bytes.size() == 0) begin
        res.out_byte    = 8'h00;
        res.byte_valid  = 1'b0;
        res.end_of_text = 1'b1;
        res.truncated   = dropped;
        expected_text   = {expected_text, res};
      end else begin
        expected_text[expected_text.size()-1].end_of_text = 1'b1;
      end
      clear_window();
      emitted_count = 0;
      dropped       = 1'b0;
    end
  endfunction

  // Only called while the block is idle, so the shadow can follow at once.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_PATTERN_BYTES: pat_word = value;
      CFG_PATTERN_LENGTH: begin
        pat_len_reg = value[3:0];
        clear_window();
      end
      CFG_REPLACEMENT_BYTES:  rep_word = value;
      CFG_REPLACEMENT_LENGTH: rep_len_reg = value[3:0];
      CFG_OUTPUT_LIMIT:       limit_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_strings(logic [63:0] pat, logic [3:0] plen, logic [63:0] rep,
                             logic [3:0] rlen);
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_PATTERN_LENGTH, {60'd0, plen});
    write_reg(CFG_REPLACEMENT_BYTES, rep);
    write_reg(CFG_REPLACEMENT_LENGTH, {60'd0, rlen});
  endtask

  // A valid that stays high for the next byte is never lowered in between.
  task automatic send_byte(logic [7:0] b, bit last);
    int  gap;
    in_t item;
    item.in_byte = b;
    item.is_last = last;
    gap = idling_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_and_replace(item);
  endtask

  task automatic send_text(logic [7:0] text [$]);
    foreach (text[k]) send_byte(text[k], k == text.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_config();
    send_text('{8'h01, 8'hFF, 8'h80, 8'h7F});
    drain();
  endtask

  task automatic test_directed_strings();
    // Three-byte pattern, leftover partial match flushed at the end.
    set_strings(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
    send_text('{8'h7A, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62});
    drain();
    // Widest pattern and replacement, all bits set.
    set_strings({64{1'b1}}, 4'd8, {64{1'b1}}, 4'd8);
    send_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    drain();
    // Deletion on the last byte leaves only a bare end marker.
    set_strings(64'h71, 4'd1, 64'h0, 4'd0);
    send_text('{8'h71});
    drain();
    // Rewriting the pattern length discards the pending partial match.
    set_strings(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    drain();
    write_reg(CFG_PATTERN_LENGTH, 64'd3);
    send_byte(8'h63, 1'b1);
    drain();
    // Length zero acts as one, oversized lengths saturate.
    set_strings(64'h41, 4'd0, 64'h3837_3635_3433_3231, 4'd15);
    send_text('{8'h41});
    drain();
    set_strings(64'h4847_4645_4443_4241, 4'd15, 64'h0, 4'd0);
    send_text('{8'h78});
    drain();
  endtask

  task automatic test_output_limit();
    set_strings(64'h61, 4'd1, 64'h3837_3635_3433_3231, 4'd8);
    write_reg(CFG_OUTPUT_LIMIT, 64'd5);
    send_text('{8'h61, 8'h61});
    send_text('{8'h62});
    drain();
    write_reg(CFG_OUTPUT_LIMIT, 64'd1);
    send_text('{8'h78, 8'h79});
    drain();
    write_reg(CFG_OUTPUT_LIMIT, 64'd0);
    send_text('{8'h7A});
    drain();
    write_reg(CFG_OUTPUT_LIMIT, 64'd65535);
  endtask

  // Every byte 0x61 expands eightfold while the receiver holds off, so the
  // job queue fills and the input side must stall.
  task automatic test_back_pressure();
    int k;
    set_strings(64'h61, 4'd1, 64'hA5C3_0F81_7E3C_5AF0, 4'd8);
    idling_on    = 1'b0;
    hold_request = HOLD_OFF;
    for (k = 0; k < 30; k++)
      send_byte((k % 7 == 3) ? 8'h62 : 8'h61, k == 29);
    drain();
    idling_on = 1'b1;
  endtask

  task automatic test_random_texts();
    int          phase;
    int          sent;
    int          len;
    int          k;
    int          cur;
    int          choice;
    int unsigned plen;
    logic [63:0] pat;
    logic [7:0]  b;
    logic [7:0]  text [$];
    for (phase = 0; phase < 8; phase++) begin
      drain();
      idling_on = (phase != 3);
      for (k = 0; k < 8; k++)
        pat[8*k +: 8] = ($urandom_range(0, 9) < 7) ? 8'(8'h60 + $urandom_range(1, 4))
                                                    : 8'($urandom_range(0, 255));
      case (phase)
        0:       plen = 1;
        1:       plen = 8;
        default: plen = $urandom_range(1, 8);
      endcase
      set_strings(pat, plen[3:0], {$urandom, $urandom}, 4'($urandom_range(0, 8)));
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_OUTPUT_LIMIT, 64'($urandom_range(2, 20)));
        1:       write_reg(CFG_OUTPUT_LIMIT,
                           (phase == 5) ? 64'd1 : 64'($urandom_range(1, 65535)));
        default: write_reg(CFG_OUTPUT_LIMIT, 64'd65535);
      endcase
      sent = 0;
      while (sent < 24) begin
        text.delete();
        len = $urandom_range(1, 10);
        cur = 0;
        for (k = 0; k < len; k++) begin
          choice = $urandom_range(0, 9);
          // Noise bytes are random and nonzero; the rest are letters a to d or follow the pattern.
          if ($urandom_range(0, 9) == 0 || choice >= 8) begin
            b   = 8'($urandom_range(1, 255));
            cur = 0;
          end else if (choice >= 6) begin
            b   = 8'(8'h60 + $urandom_range(1, 4));
            cur = 0;
          end else begin
            b   = pat[8*(cur % plen) +: 8];
            cur = cur + 1;
            if (b == 8'h00) b = 8'($urandom_range(1, 255));
          end
          text = {text, b};
        end
        send_text(text);
        sent += len;
      end
    end
    idling_on = 1'b1;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        $error("result transfer with nothing expected: out_byte %h", out_data.out_byte);
        fail_count++;
      end else begin
        want = expected_text.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
          fail_count++;
        end
        if (out_data.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %b, got %b", want.byte_valid, out_data.byte_valid);
          fail_count++;
        end
        if (out_data.end_of_text !== want.end_of_text) begin
          $error("end_of_text: expected %b, got %b", want.end_of_text,
                 out_data.end_of_text);
          fail_count++;
        end
        if (out_data.truncated !== want.truncated) begin
          $error("truncated: expected %b, got %b", want.truncated, out_data.truncated);
          fail_count++;
        end
      end
    end
  end

  // Receiver: a random stall after each transfer, now and then while idle,
  // and one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (idling_on && stall_left == 0) begin
        if (out_valid && !out_stall) stall_left = $urandom_range(0, 5);
        else if (!out_valid && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** streaming_substring_replace: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_default_config();
    test_directed_strings();
    test_output_limit();
    test_back_pressure();
    test_random_texts();
    drain();
    if (fail_count == 0) begin
      $display("** streaming_substring_replace: PASSED **");
    end else begin
      $display("** streaming_substring_replace: FAILED **");
    end
    $finish;
  end

endmodule
